// ----- design/mtrt_pkg.sv -----
`timescale 1ns / 1ps

package mtrt_pkg;

   // default geometry limits
   localparam int DEF_MAX_TILES_X = 64;
   localparam int DEF_MAX_TILES_Y = 64;
   localparam int DEF_MAX_LEVELS  = 8;

   // field widths
   localparam int COORD_W        = 6;
   localparam int LEVEL_W        = 3;
   localparam int STORED_LEVEL_W = 4;
   localparam int KIND_W         = 2;
   localparam int COUNT_W        = 13;
   localparam int SIZE_REG_W     = 7;
   localparam int MIPS_REG_W     = 4;
   localparam int CSR_DATA_W     = 7;
   localparam int CSR_INDEX_W    = 2;
   localparam int REQ_DATA_W     = 16;
   localparam int RSP_DATA_W     = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1fff;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TILES_WIDE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILES_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIP_COUNT  = 2'd2;

   // register reset values
   localparam logic [SIZE_REG_W-1:0] RST_TILES = 7'd64;
   localparam logic [MIPS_REG_W-1:0] RST_MIPS  = 4'd7;

   // event kinds
   localparam logic [KIND_W-1:0] EV_LOAD    = 2'd0;
   localparam logic [KIND_W-1:0] EV_UNLOAD  = 2'd1;
   localparam logic [KIND_W-1:0] EV_ILLEGAL = 2'd2;

endpackage

// ----- design/mip_tile_residency_tracker_unit.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// req_      in         req_tvalid/tready    tdata: tile_x, tile_y, wanted_level
// rsp_      out        rsp_tvalid/tready    tdata: event_x, event_y, event_level;
//                                           tuser: event_kind; tlast: last
// csr_      in         csr_we               csr_index, csr_wdata
//
// a legal request walks every level below hi, where lo and hi
// bound the levels between the stored and the wanted level; each level runs a
// product step, an address step and, inside the range, one count read-modify-write
// on the count memory. an illegal request skips the walk and sends one illegal event.
// after reset and after every register write the block sweeps both memories, one
// entry a cycle, all REF_DEPTH entries (5726 at the defaults), with req_tready low.
// a stalled rsp_ side holds the sequencer only when a new event must be pushed.
module mip_tile_residency_tracker_unit #(
   parameter int MAX_TILES_X = mtrt_pkg::DEF_MAX_TILES_X,
   parameter int MAX_TILES_Y = mtrt_pkg::DEF_MAX_TILES_Y,
   parameter int MAX_LEVELS  = mtrt_pkg::DEF_MAX_LEVELS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tile_x [5:0], tile_y [11:6], wanted_level [14:12]
   input  logic [mtrt_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // event_x [5:0], event_y [11:6], event_level [14:12]
   output logic [mtrt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // event_kind [1:0]
   output logic [mtrt_pkg::KIND_W-1:0]          rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [mtrt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mtrt_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import mtrt_pkg::*;

   localparam int CELL_DEPTH = MAX_TILES_X * MAX_TILES_Y;
   localparam int REF_DEPTH  = (CELL_DEPTH * 4) / 3 + 2 * (MAX_TILES_X + MAX_TILES_Y)
                               + MAX_LEVELS + 1;
   localparam int CW   = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
   localparam int RAW  = $clog2(REF_DEPTH);
   localparam int OFFW = $clog2(REF_DEPTH + 1);
   localparam int IDW  = OFFW + 1;
   localparam int WW   = $clog2(MAX_TILES_X + 1);
   localparam int HW   = $clog2(MAX_TILES_Y + 1);
   localparam int SW   = WW + 8;
   localparam int SHW  = HW + 8;
   localparam int PAW  = WW + COORD_W;
   localparam int PBW  = WW + HW;
   localparam int CPW  = COORD_W + WW;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_LREAD = 4'd2;
   localparam logic [3:0] ST_SETUP = 4'd3;
   localparam logic [3:0] ST_PROD  = 4'd4;
   localparam logic [3:0] ST_ADDR  = 4'd5;
   localparam logic [3:0] ST_RMW   = 4'd6;
   localparam logic [3:0] ST_DONE  = 4'd7;
   localparam logic [3:0] ST_ILL   = 4'd8;

   localparam logic [STORED_LEVEL_W-1:0] LVL_LIMIT = STORED_LEVEL_W'(MAX_LEVELS);

   // control registers
   logic [3:0]                state_ff, state_in;
   logic [RAW-1:0]            clr_ff, clr_in;
   logic [SIZE_REG_W-1:0]     tiles_wide_ff, tiles_wide_in;
   logic [SIZE_REG_W-1:0]     tiles_high_ff, tiles_high_in;
   logic [MIPS_REG_W-1:0]     mip_count_ff, mip_count_in;
   logic                      pend_valid_ff, pend_valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [COORD_W-1:0]        x_ff, x_in, y_ff, y_in;
   logic [LEVEL_W-1:0]        want_ff, want_in;
   logic [CW-1:0]             cell_ff, cell_in;
   logic                      loading_ff, loading_in;
   logic [STORED_LEVEL_W-1:0] lo_ff, lo_in, hi_ff, hi_in, lvl_ff, lvl_in;
   logic [OFFW-1:0]           off_ff, off_in;
   logic [PAW-1:0]            prod_a_ff, prod_a_in;
   logic [PBW-1:0]            prod_b_ff, prod_b_in;
   logic [COORD_W-1:0]        mx_ff, mx_in, my_ff, my_in;
   logic [RAW-1:0]            ref_addr_ff, ref_addr_in;
   logic [KIND_W-1:0]         pend_kind_ff, pend_kind_in;
   logic [COORD_W-1:0]        pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic [LEVEL_W-1:0]        pend_lvl_ff, pend_lvl_in;
   logic [KIND_W-1:0]         rsp_kind_ff, rsp_kind_in;
   logic [COORD_W-1:0]        rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [LEVEL_W-1:0]        rsp_lvl_ff, rsp_lvl_in;
   logic                      rsp_last_ff, rsp_last_in;

   // memories
   logic [STORED_LEVEL_W-1:0] lvl_mem [CELL_DEPTH];
   logic [COUNT_W-1:0]        ref_mem [REF_DEPTH];
   logic [STORED_LEVEL_W-1:0] lvl_rd_ff;
   logic [COUNT_W-1:0]        ref_rd_ff;
   logic                      lvl_we, ref_we, ref_re;
   logic [CW-1:0]             lvl_waddr;
   logic [STORED_LEVEL_W-1:0] lvl_wdata;
   logic [RAW-1:0]            ref_waddr, ref_raddr;
   logic [COUNT_W-1:0]        ref_wdata;

   // combinational helpers
   logic [WW-1:0]             eff_w, lw;
   logic [HW-1:0]             eff_h, lh;
   logic [STORED_LEVEL_W-1:0] eff_m, old_lvl, want_ext;
   logic [COORD_W-1:0]        req_x, req_y;
   logic [LEVEL_W-1:0]        req_want;
   logic                      req_legal, out_free, ev_fire, csr_hit;
   logic [CPW-1:0]            cell_calc;
   logic [SW-1:0]             lw_full;
   logic [SHW-1:0]            lh_full;
   logic [COORD_W-1:0]        my_c;
   logic [IDW-1:0]            idx;

   assign req_x    = req_tdata[COORD_W-1:0];
   assign req_y    = req_tdata[2*COORD_W-1:COORD_W];
   assign req_want = req_tdata[2*COORD_W+LEVEL_W-1:2*COORD_W];

   // effective geometry, clamped to the supported range
   assign eff_w = (tiles_wide_ff == '0) ? WW'(1) :
                  ((32'(tiles_wide_ff) > 32'(MAX_TILES_X)) ? WW'(MAX_TILES_X) :
                   WW'(tiles_wide_ff));
   assign eff_h = (tiles_high_ff == '0) ? HW'(1) :
                  ((32'(tiles_high_ff) > 32'(MAX_TILES_Y)) ? HW'(MAX_TILES_Y) :
                   HW'(tiles_high_ff));
   assign eff_m = (mip_count_ff == '0) ? STORED_LEVEL_W'(1) :
                  ((mip_count_ff > LVL_LIMIT) ? LVL_LIMIT : mip_count_ff);

   assign req_legal = ({1'b0, req_want} < eff_m) && (32'(req_x) < 32'(eff_w))
                      && (32'(req_y) < 32'(eff_h));
   assign cell_calc = CPW'(req_y) * CPW'(eff_w) + CPW'(req_x);

   // level size, rounded up
   assign lw_full = (SW'(eff_w) + (SW'(1) << lvl_ff) - SW'(1)) >> lvl_ff;
   assign lh_full = (SHW'(eff_h) + (SHW'(1) << lvl_ff) - SHW'(1)) >> lvl_ff;
   assign lw      = WW'(lw_full);
   assign lh      = HW'(lh_full);
   assign my_c    = y_ff >> lvl_ff;

   assign idx      = IDW'(off_ff) + IDW'(prod_a_ff) + IDW'(mx_ff);
   assign ref_raddr = RAW'(idx);
   assign old_lvl  = (lvl_rd_ff > LVL_LIMIT) ? LVL_LIMIT : lvl_rd_ff;
   assign want_ext = {1'b0, want_ff};
   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign ev_fire  = loading_ff ? (ref_rd_ff == '0) : (ref_rd_ff == COUNT_W'(1));
   assign csr_hit  = csr_we && ((csr_index == CSR_TILES_WIDE) ||
                                (csr_index == CSR_TILES_HIGH) ||
                                (csr_index == CSR_MIP_COUNT));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      tiles_wide_in = tiles_wide_ff;
      tiles_high_in = tiles_high_ff;
      mip_count_in  = mip_count_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      x_in          = x_ff;
      y_in          = y_ff;
      want_in       = want_ff;
      cell_in       = cell_ff;
      loading_in    = loading_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      lvl_in        = lvl_ff;
      off_in        = off_ff;
      prod_a_in     = prod_a_ff;
      prod_b_in     = prod_b_ff;
      mx_in         = mx_ff;
      my_in         = my_ff;
      ref_addr_in   = ref_addr_ff;
      pend_kind_in  = pend_kind_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      pend_lvl_in   = pend_lvl_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_lvl_in    = rsp_lvl_ff;
      rsp_last_in   = rsp_last_ff;
      lvl_we        = 1'b0;
      lvl_waddr     = cell_ff;
      lvl_wdata     = want_ext;
      ref_we        = 1'b0;
      ref_waddr     = ref_addr_ff;
      ref_wdata     = ref_rd_ff;
      ref_re        = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            ref_we    = 1'b1;
            ref_waddr = clr_ff;
            ref_wdata = '0;
            if (32'(clr_ff) < 32'(CELL_DEPTH)) begin
               lvl_we    = 1'b1;
               lvl_waddr = CW'(clr_ff);
               lvl_wdata = eff_m;
            end
            if (32'(clr_ff) == 32'(REF_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               x_in     = req_x;
               y_in     = req_y;
               want_in  = req_want;
               cell_in  = CW'(cell_calc);
               state_in = req_legal ? ST_LREAD : ST_ILL;
            end
         end
         ST_LREAD: begin
            state_in = ST_SETUP;
         end
         // direction and level range of the walk
         ST_SETUP: begin
            loading_in = old_lvl > want_ext;
            lo_in      = (old_lvl > want_ext) ? want_ext : old_lvl;
            hi_in      = (old_lvl > want_ext) ? old_lvl : want_ext;
            lvl_in     = '0;
            off_in     = '0;
            state_in   = ST_PROD;
         end
         // products for the covering tile and the level size
         ST_PROD: begin
            if ((lvl_ff >= hi_ff) || (lvl_ff >= LVL_LIMIT)) begin
               state_in = ST_DONE;
            end else begin
               prod_a_in = PAW'(lw) * PAW'(my_c);
               prod_b_in = PBW'(lw) * PBW'(lh);
               mx_in     = x_ff >> lvl_ff;
               my_in     = my_c;
               state_in  = ST_ADDR;
            end
         end
         // count address and read, next level offset
         ST_ADDR: begin
            off_in = off_ff + OFFW'(prod_b_ff);
            if ((lvl_ff >= lo_ff) && (32'(idx) < 32'(REF_DEPTH))) begin
               ref_re      = 1'b1;
               ref_addr_in = ref_raddr;
               state_in    = ST_RMW;
            end else begin
               lvl_in   = lvl_ff + 1'b1;
               state_in = ST_PROD;
            end
         end
         // count update, events held back one step to mark the last one
         ST_RMW: begin
            if (!(ev_fire && pend_valid_ff && !out_free)) begin
               if (loading_ff) begin
                  if (ref_rd_ff != COUNT_MAX) begin
                     ref_we    = 1'b1;
                     ref_wdata = ref_rd_ff + 1'b1;
                  end
               end else if (ref_rd_ff != '0) begin
                  ref_we    = 1'b1;
                  ref_wdata = ref_rd_ff - 1'b1;
               end
               if (ev_fire) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = pend_kind_ff;
                     rsp_x_in     = pend_x_ff;
                     rsp_y_in     = pend_y_ff;
                     rsp_lvl_in   = pend_lvl_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_kind_in  = loading_ff ? EV_LOAD : EV_UNLOAD;
                  pend_x_in     = mx_ff;
                  pend_y_in     = my_ff;
                  pend_lvl_in   = lvl_ff[LEVEL_W-1:0];
               end
               lvl_in   = lvl_ff + 1'b1;
               state_in = ST_PROD;
            end
         end
         // store the new level, flush the held event as last
         ST_DONE: begin
            if (!pend_valid_ff || out_free) begin
               lvl_we = 1'b1;
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = pend_kind_ff;
                  rsp_x_in     = pend_x_ff;
                  rsp_y_in     = pend_y_ff;
                  rsp_lvl_in   = pend_lvl_ff;
                  rsp_last_in  = 1'b1;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         ST_ILL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = EV_ILLEGAL;
               rsp_x_in     = x_ff;
               rsp_y_in     = y_ff;
               rsp_lvl_in   = want_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase

      // register write restarts the clearing sweep
      if (csr_hit) begin
         if (csr_index == CSR_TILES_WIDE) begin
            tiles_wide_in = csr_wdata[SIZE_REG_W-1:0];
         end
         if (csr_index == CSR_TILES_HIGH) begin
            tiles_high_in = csr_wdata[SIZE_REG_W-1:0];
         end
         if (csr_index == CSR_MIP_COUNT) begin
            mip_count_in = csr_wdata[MIPS_REG_W-1:0];
         end
         state_in      = ST_CLEAR;
         clr_in        = '0;
         pend_valid_in = 1'b0;
         rsp_valid_in  = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         tiles_wide_ff <= RST_TILES;
         tiles_high_ff <= RST_TILES;
         mip_count_ff  <= RST_MIPS;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         tiles_wide_ff <= tiles_wide_in;
         tiles_high_ff <= tiles_high_in;
         mip_count_ff  <= mip_count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      want_ff      <= want_in;
      cell_ff      <= cell_in;
      loading_ff   <= loading_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      lvl_ff       <= lvl_in;
      off_ff       <= off_in;
      prod_a_ff    <= prod_a_in;
      prod_b_ff    <= prod_b_in;
      mx_ff        <= mx_in;
      my_ff        <= my_in;
      ref_addr_ff  <= ref_addr_in;
      pend_kind_ff <= pend_kind_in;
      pend_x_ff    <= pend_x_in;
      pend_y_ff    <= pend_y_in;
      pend_lvl_ff  <= pend_lvl_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_lvl_ff   <= rsp_lvl_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // stored level per base tile
   always_ff @(posedge clock) begin
      if (lvl_we) begin
         lvl_mem[lvl_waddr] <= lvl_wdata;
      end
      lvl_rd_ff <= lvl_mem[cell_ff];
   end

   // reference counts for every tile of every level
   always_ff @(posedge clock) begin
      if (ref_we) begin
         ref_mem[ref_waddr] <= ref_wdata;
      end
      if (ref_re) begin
         ref_rd_ff <= ref_mem[ref_raddr];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_lvl_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- test/mip_tile_residency_tracker_unit_tb.sv -----
`timescale 1ns / 1ps

module mip_tile_residency_tracker_unit_tb;
   import mtrt_pkg::*;

   localparam int TILE_CELLS   = DEF_MAX_TILES_X * DEF_MAX_TILES_Y;
   localparam int COUNT_CELLS  = (TILE_CELLS * 4) / 3 + 2 * (DEF_MAX_TILES_X + DEF_MAX_TILES_Y)
                                 + DEF_MAX_LEVELS + 1;
   // covers the longest legal request, with margin
   localparam int BUSY_CYCLES  = 40;
   localparam int SWEEP_CYCLES = COUNT_CELLS + 100;
   localparam int IDLE_LIMIT   = 20000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   // receiver stall patterns
   localparam int RSP_ALWAYS  = 0;
   localparam int RSP_RANDOM  = 1;
   localparam int RSP_PATTERN = 2;
   localparam int RSP_MOSTLY  = 3;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [LEVEL_W-1:0] lvl;
      logic               last;
   } tile_event_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [KIND_W-1:0]      rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // tracker copy: registers, stored levels and reference counts
   logic [SIZE_REG_W-1:0]     reg_tiles_wide;
   logic [SIZE_REG_W-1:0]     reg_tiles_high;
   logic [MIPS_REG_W-1:0]     reg_mip_count;
   logic [STORED_LEVEL_W-1:0] stored_level [TILE_CELLS];
   logic [COUNT_W-1:0]        tile_refs [COUNT_CELLS];

   tile_event_type pending_events[$];
   int          mismatch_count = 0;
   int          rsp_stall_mode = RSP_ALWAYS;
   int          hold_left = 0;
   bit          pacing_on = 0;
   int          burst_left = 0;
   bit          sweep_pending = 1;
   int          quiet_cycles = 0;

   mip_tile_residency_tracker_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clamp_to(input int v, input int top);
      if (v < 1) return 1;
      if (v > top) return top;
      return v;
   endfunction

   // state after reset or any register write
   task automatic clear_tracker_state();
      int mips;
      mips = clamp_to(reg_mip_count, DEF_MAX_LEVELS);
      foreach (stored_level[i]) stored_level[i] = mips[STORED_LEVEL_W-1:0];
      foreach (tile_refs[i]) tile_refs[i] = '0;
   endtask

   // update counts for one accepted request and queue the events it causes
   task automatic track_residency(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                  input logic [LEVEL_W-1:0] want);
      int          w, h, m, base_cell, prev, lo, hi, off, lw, lh, mx, my, idx, lvl;
      bit          loading;
      tile_event_type ev;
      tile_event_type found[$];
      w = clamp_to(reg_tiles_wide, DEF_MAX_TILES_X);
      h = clamp_to(reg_tiles_high, DEF_MAX_TILES_Y);
      m = clamp_to(reg_mip_count, DEF_MAX_LEVELS);
      // illegal request leaves the state alone
      if (want >= m || x >= w || y >= h) begin
         ev.kind = EV_ILLEGAL;
         ev.x    = x;
         ev.y    = y;
         ev.lvl  = want;
         ev.last = 1'b1;
         pending_events.push_back(ev);
         return;
      end
      base_cell = y * w + x;
      prev = stored_level[base_cell];
      if (prev > DEF_MAX_LEVELS) prev = DEF_MAX_LEVELS;
      loading = prev > want;
      lo = loading ? want : prev;
      hi = loading ? prev : want;
      off = 0;
      // walk the levels in ascending order, offsets follow the rounded-up sizes
      for (lvl = 0; lvl < hi && lvl < DEF_MAX_LEVELS; lvl++) begin
         lw = (w + (1 << lvl) - 1) >> lvl;
         lh = (h + (1 << lvl) - 1) >> lvl;
         if (lvl >= lo) begin
            mx = x >> lvl;
            my = y >> lvl;
            idx = off + lw * my + mx;
            ev.x    = mx[COORD_W-1:0];
            ev.y    = my[COORD_W-1:0];
            ev.lvl  = lvl[LEVEL_W-1:0];
            ev.last = 1'b0;
            if (idx < COUNT_CELLS) begin
               if (loading) begin
                  if (tile_refs[idx] == '0) begin
                     ev.kind = EV_LOAD;
                     found.push_back(ev);
                  end
                  if (tile_refs[idx] != COUNT_MAX) tile_refs[idx] = tile_refs[idx] + 1'b1;
               end else if (tile_refs[idx] != '0) begin
                  if (tile_refs[idx] == 1) begin
                     ev.kind = EV_UNLOAD;
                     found.push_back(ev);
                  end
                  tile_refs[idx] = tile_refs[idx] - 1'b1;
               end
            end
         end
         off += lw * lh;
      end
      stored_level[base_cell] = {1'b0, want};
      if (found.size() > 0) found[found.size()-1].last = 1'b1;
      foreach (found[i]) pending_events.push_back(found[i]);
   endtask

   // receiver: long hold-off on request, otherwise the current stall pattern
   initial begin
      int tick;
      tick = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rsp_stall_mode)
               RSP_RANDOM:  rsp_tready <= 1'($urandom_range(0, 1));
               RSP_PATTERN: rsp_tready <= (tick % 7) < 4;
               RSP_MOSTLY:  rsp_tready <= $urandom_range(0, 7) != 0;
               default:     rsp_tready <= 1'b1;
            endcase
         end
      end
   end

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // compare each accepted event with the oldest prediction
   always @(posedge clock) begin
      tile_event_type oldest;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_events.size() == 0) begin
            $display("%0t unexpected event: expected none actual kind %0d x %0d y %0d lvl %0d last %0d",
                     $time, rsp_tuser, rsp_tdata[5:0], rsp_tdata[11:6], rsp_tdata[14:12],
                     rsp_tlast);
            mismatch_count++;
         end else begin
            oldest = pending_events.pop_front();
            check_field("event_kind", int'(oldest.kind), int'(rsp_tuser));
            check_field("event_x", int'(oldest.x), int'(rsp_tdata[5:0]));
            check_field("event_y", int'(oldest.y), int'(rsp_tdata[11:6]));
            check_field("event_level", int'(oldest.lvl), int'(rsp_tdata[14:12]));
            check_field("last", int'(oldest.last), int'(rsp_tlast));
         end
      end
   end

   // watchdog on cycles without any handshake or register write
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t watchdog: no traffic for %0d cycles, %0d events outstanding",
                     $time, IDLE_LIMIT, pending_events.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   // one request, with burst gaps when pacing is on
   task automatic send_tile_request(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                    input logic [LEVEL_W-1:0] want);
      int gap;
      gap = 0;
      if (pacing_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(1, 6);
         end
         burst_left--;
      end
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, want, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_residency(x, y, want);
   endtask

   // mostly in the given span, sometimes anywhere in the field range
   task automatic send_random_tile(input int xspan, input int yspan, input int lvlspan);
      logic [COORD_W-1:0] x, y;
      logic [LEVEL_W-1:0] want;
      if ($urandom_range(0, 9) == 0) begin
         x    = COORD_W'($urandom_range(0, 63));
         y    = COORD_W'($urandom_range(0, 63));
         want = LEVEL_W'($urandom_range(0, 7));
      end else begin
         x    = COORD_W'($urandom_range(0, xspan));
         y    = COORD_W'($urandom_range(0, yspan));
         want = LEVEL_W'($urandom_range(0, lvlspan));
      end
      send_tile_request(x, y, want);
   endtask

   task automatic wait_events_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
   endtask

   // register write once the block has gone quiet
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      wait_events_drained();
      repeat (BUSY_CYCLES + (sweep_pending ? SWEEP_CYCLES : 0)) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      sweep_pending = 1;
      case (idx)
         CSR_TILES_WIDE: reg_tiles_wide = value;
         CSR_TILES_HIGH: reg_tiles_high = value;
         CSR_MIP_COUNT:  reg_mip_count  = value[MIPS_REG_W-1:0];
         default: return;
      endcase
      clear_tracker_state();
   endtask

   // default geometry: full chains of loads and unloads, shared parents, illegal level
   task automatic test_directed_defaults();
      rsp_stall_mode = RSP_ALWAYS;
      pacing_on = 0;
      send_tile_request(6'd0, 6'd0, 3'd0);
      send_tile_request(6'd0, 6'd0, 3'd0);
      send_tile_request(6'd1, 6'd1, 3'd0);
      send_tile_request(6'd0, 6'd0, 3'd3);
      send_tile_request(6'd63, 6'd63, 3'd0);
      send_tile_request(6'd63, 6'd63, 3'd7);
      send_tile_request(6'd63, 6'd63, 3'd6);
      send_tile_request(6'd42, 6'd21, 3'd5);
      send_tile_request(6'd21, 6'd42, 3'd2);
      send_tile_request(6'd1, 6'd1, 3'd6);
      send_tile_request(6'd0, 6'd0, 3'd6);
   endtask

   // index beyond the register list changes nothing
   task automatic test_ignored_index();
      write_register(CSR_UNUSED, 7'h7f);
      send_tile_request(6'd5, 6'd9, 3'd1);
   endtask

   // clamped geometry at both ends of each register
   task automatic test_geometry_extremes();
      rsp_stall_mode = RSP_MOSTLY;
      write_register(CSR_TILES_WIDE, 7'd0);
      write_register(CSR_TILES_HIGH, 7'h7f);
      write_register(CSR_MIP_COUNT, 7'h7f);
      send_tile_request(6'd0, 6'd0, 3'd0);
      send_tile_request(6'd0, 6'd63, 3'd0);
      send_tile_request(6'd0, 6'd0, 3'd7);
      send_tile_request(6'd1, 6'd0, 3'd3);
      send_tile_request(6'd0, 6'd32, 3'd4);
      send_tile_request(6'd0, 6'd63, 3'd7);
      write_register(CSR_TILES_WIDE, 7'h7f);
      write_register(CSR_TILES_HIGH, 7'd0);
      write_register(CSR_MIP_COUNT, 7'd0);
      send_tile_request(6'd63, 6'd0, 3'd0);
      send_tile_request(6'd63, 6'd0, 3'd1);
      send_tile_request(6'd5, 6'd1, 3'd0);
      send_tile_request(6'd63, 6'd0, 3'd0);
      write_register(CSR_MIP_COUNT, 7'd8);
      send_tile_request(6'd63, 6'd0, 3'd0);
      send_tile_request(6'd62, 6'd0, 3'd7);
      send_tile_request(6'd63, 6'd0, 3'd7);
   endtask

   // odd sizes exercise the rounded-up level offsets
   task automatic test_odd_grid_random();
      write_register(CSR_TILES_WIDE, 7'd5);
      write_register(CSR_TILES_HIGH, 7'd3);
      write_register(CSR_MIP_COUNT, 7'd8);
      rsp_stall_mode = RSP_PATTERN;
      pacing_on = 1;
      repeat (80) send_random_tile(5, 3, 7);
   endtask

   // clustered base tiles so coarse parents are shared
   task automatic test_wide_grid_random();
      int base_x, base_y;
      write_register(CSR_TILES_WIDE, 7'd64);
      write_register(CSR_TILES_HIGH, 7'd64);
      write_register(CSR_MIP_COUNT, 7'd6);
      rsp_stall_mode = RSP_ALWAYS;
      pacing_on = 0;
      base_x = 0;
      base_y = 0;
      for (int i = 0; i < 100; i++) begin
         if (i % 20 == 0) begin
            base_x = $urandom_range(0, 56);
            base_y = $urandom_range(0, 56);
         end
         if (i == 30) begin
            rsp_stall_mode = RSP_RANDOM;
            pacing_on = 1;
         end
         if ($urandom_range(0, 7) == 0)
            send_random_tile(63, 63, 7);
         else
            send_tile_request(COORD_W'(base_x + $urandom_range(0, 7)),
                              COORD_W'(base_y + $urandom_range(0, 7)),
                              LEVEL_W'($urandom_range(0, 5)));
      end
   endtask

   // receiver holds off while requests keep coming, then a full drain
   task automatic test_backpressure();
      write_register(CSR_TILES_WIDE, 7'd8);
      write_register(CSR_TILES_HIGH, 7'd8);
      write_register(CSR_MIP_COUNT, 7'd8);
      rsp_stall_mode = RSP_ALWAYS;
      pacing_on = 0;
      hold_left = 400;
      for (int i = 0; i < 30; i++)
         send_tile_request(COORD_W'($urandom_range(0, 7)), COORD_W'($urandom_range(0, 7)),
                           (i % 2) ? 3'd7 : 3'd0);
      wait_events_drained();
      rsp_stall_mode = RSP_RANDOM;
      pacing_on = 1;
      repeat (30) send_random_tile(8, 8, 7);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      reg_tiles_wide = RST_TILES;
      reg_tiles_high = RST_TILES;
      reg_mip_count  = RST_MIPS;
      clear_tracker_state();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_defaults();
      test_ignored_index();
      test_geometry_extremes();
      test_odd_grid_random();
      test_wide_grid_random();
      test_backpressure();

      wait_events_drained();
      repeat (BUSY_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_events.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
